/* hdl/bfa_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// Bitmap frame allocator package
// Request codes, result status codes and a bit search helper.
// ============================================================================
package bfa_pkg;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_OOM          = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_RANGE        = 2'd3
    } t_status;

    localparam int          MAP_BITS   = 64;
    localparam int          ADDR_W     = 28;
    localparam int          COUNT_W    = 17;
    localparam logic [16:0] COUNT_MAX  = 17'h1FFFF;

    // Index of the lowest set bit of a 64-bit word; zero for an empty word.
    function automatic logic [5:0] lowest_one64(input logic [63:0] v);
        logic [5:0] r;
        r = '0;
        for (int i = MAP_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = 6'(i);
            end
        end
        return r;
    endfunction

endpackage

/* hdl/bfa_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// Bitmap frame allocator channels
// Valid/ready request and result channels with their payloads.
// ============================================================================
interface bfa_req_if;
    import bfa_pkg::*;

    logic        valid;
    logic        ready;
    t_op         operation;
    logic [31:0] frame_address;

    modport source (output valid, output operation, output frame_address, input ready);
    modport sink   (input valid, input operation, input frame_address, output ready);
endinterface

interface bfa_rsp_if;
    import bfa_pkg::*;

    logic        valid;
    logic        ready;
    logic [27:0] result_address;
    t_status     status;
    logic [16:0] free_count;

    modport source (output valid, output result_address, output status, output free_count,
                    input ready);
    modport sink   (input valid, input result_address, input status, input free_count,
                    output ready);
endinterface

/* hdl/bitmap_frame_allocator.sv */
`timescale 1ns / 1ps
// Sequencing: an allocate request reads its summary word on acceptance, its map word in S_RDS
//   and registers its result in S_MOD; an out-of-memory allocate and a free go straight to S_MOD.
// Throughput: one request at a time, set by the dependent summary and map reads; a waiting
//   result holds the input.
// Reset clears the state machine, the summary-valid flags, the free count and the output valid;
//   the memories need no clearing pass because a cleared flag makes its word read as full.
// ============================================================================
// Bitmap frame allocator
// First-fit physical frame allocator over a used-bit map with a two-level
// summary of words that still hold a free frame.
// ============================================================================
module bitmap_frame_allocator #(
    parameter int MAP_WORDS = 1024,
    parameter int PAGE_BITS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bfa_req_if.sink   i_req,
    bfa_rsp_if.source o_rsp
);
    import bfa_pkg::*;

    localparam int SUM_WORDS  = (MAP_WORDS + 63) / 64;
    localparam int WORD_BITS  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SUM_BITS   = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int FRAME_BITS = WORD_BITS + 6;
    localparam int SHIFT_W    = 48;
    localparam logic [32:0] FRAMES     = 33'(MAP_WORDS) << 6;
    localparam logic [32:0] FREE_LIMIT = (FRAMES > 33'(COUNT_MAX)) ? 33'(COUNT_MAX) : FRAMES;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RDS  = 3'b010,
        S_MOD  = 3'b100
    } t_state;

    // Priority encoder over the top-level summary flags.
    function automatic logic [SUM_BITS-1:0] lowest_top(input logic [SUM_WORDS-1:0] v);
        logic [SUM_BITS-1:0] r;
        r = '0;
        for (int i = SUM_WORDS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = SUM_BITS'(i);
            end
        end
        return r;
    endfunction

    // Used-bit map and summary memories (summary bit set = map word has a free frame).
    logic [63:0] r_map [MAP_WORDS];
    logic [63:0] r_sum [SUM_WORDS];
    logic [63:0] r_map_q;
    logic [63:0] r_sum_q;

    t_state               r_state;
    logic [SUM_WORDS-1:0] r_top;
    logic [16:0]          r_free;
    logic                 r_out_valid;
    logic [27:0]          r_out_addr;
    t_status              r_out_status;

    logic                 r_alloc;
    logic                 r_bad;
    logic [SUM_BITS-1:0]  r_sidx;
    logic [5:0]           r_sbit;
    logic [WORD_BITS-1:0] r_word;
    logic [5:0]           r_bit;

    logic                 map_rd_en;
    logic [WORD_BITS-1:0] map_rd_addr;
    logic                 sum_rd_en;
    logic [SUM_BITS-1:0]  sum_rd_addr;
    logic                 map_wr_en;
    logic [63:0]          map_wr_data;
    logic                 sum_wr_en;
    logic [63:0]          sum_wr_data;

    logic                 accept;
    logic                 out_free;
    logic                 complete;
    logic [31:0]          req_frame;
    logic                 req_range;
    logic [SUM_BITS-1:0]  top_idx;
    logic [5:0]           sum_low;
    logic [SUM_BITS+5:0]  alloc_word;
    logic [63:0]          sum_eff;
    logic [63:0]          map_eff;
    logic [5:0]           zero_bit;
    logic                 was_used;
    logic                 do_update;
    logic                 new_top;
    logic [FRAME_BITS-1:0] alloc_frame;
    logic [SHIFT_W-1:0]   alloc_shift;
    logic [27:0]          n_out_addr;
    t_status              n_out_status;
    logic [16:0]          n_free;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign complete    = (r_state == S_MOD) && out_free;

    assign req_frame = i_req.frame_address >> PAGE_BITS;
    assign req_range = ({1'b0, req_frame} >= FRAMES);
    assign top_idx   = lowest_top(r_top);
    assign sum_low   = lowest_one64(r_sum_q);
    assign alloc_word = {r_sidx, sum_low};

    // A cleared flag one level up marks the stored word stale; it then reads as all zeros (summary) or all ones (map).
    assign sum_eff  = r_top[r_sidx] ? r_sum_q : '0;
    assign map_eff  = sum_eff[r_sbit] ? r_map_q : '1;
    assign zero_bit = lowest_one64(~map_eff);
    assign was_used = map_eff[r_bit];

    assign alloc_frame = {r_word, zero_bit};
    assign alloc_shift = SHIFT_W'(alloc_frame) << PAGE_BITS;

    always_comb begin
        map_rd_en   = 1'b0;
        map_rd_addr = req_frame[6 +: WORD_BITS];
        sum_rd_en   = 1'b0;
        sum_rd_addr = req_frame[12 +: SUM_BITS];
        if (accept) begin
            sum_rd_en = 1'b1;
            if (i_req.operation == OP_ALLOC) begin
                sum_rd_addr = top_idx;
            end else begin
                map_rd_en = 1'b1;
            end
        end else if (r_state == S_RDS) begin
            map_rd_en   = 1'b1;
            map_rd_addr = alloc_word[WORD_BITS-1:0];
        end
    end

    always_comb begin
        map_wr_data  = map_eff;
        sum_wr_data  = sum_eff;
        new_top      = 1'b1;
        do_update    = 1'b0;
        n_out_addr   = '0;
        n_out_status = ST_OK;
        n_free       = r_free;
        if (r_alloc) begin
            map_wr_data = map_eff | (64'd1 << zero_bit);
            if (&map_wr_data) begin
                sum_wr_data = sum_eff & ~(64'd1 << r_sbit);
            end
            new_top = |sum_wr_data;
            if (r_bad) begin
                n_out_status = ST_OOM;
            end else begin
                do_update  = 1'b1;
                n_out_addr = alloc_shift[ADDR_W-1:0];
                if (r_free != '0) begin
                    n_free = r_free - 17'd1;
                end
            end
        end else begin
            map_wr_data = map_eff & ~(64'd1 << r_bit);
            sum_wr_data = sum_eff | (64'd1 << r_sbit);
            if (r_bad) begin
                n_out_status = ST_RANGE;
            end else if (!was_used) begin
                n_out_status = ST_ALREADY_FREE;
            end else begin
                do_update = 1'b1;
                if (r_free != COUNT_MAX) begin
                    n_free = r_free + 17'd1;
                end
            end
        end
    end

    assign map_wr_en = complete && do_update;
    assign sum_wr_en = complete && do_update;

    always_ff @(posedge i_clk) begin
        if (map_wr_en) begin
            r_map[r_word] <= map_wr_data;
        end
        if (map_rd_en) begin
            r_map_q <= r_map[map_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sum_wr_en) begin
            r_sum[r_sidx] <= sum_wr_data;
        end
        if (sum_rd_en) begin
            r_sum_q <= r_sum[sum_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_req.operation == OP_ALLOC && r_top != '0) begin
                            r_state <= S_RDS;
                        end else begin
                            r_state <= S_MOD;
                        end
                    end
                end
                S_RDS: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (complete) begin
                r_out_valid <= 1'b1;
                r_free      <= n_free;
                if (do_update) begin
                    r_top[r_sidx] <= new_top;
                end
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_alloc <= (i_req.operation == OP_ALLOC);
            if (i_req.operation == OP_ALLOC) begin
                r_bad  <= (r_top == '0);
                r_sidx <= top_idx;
            end else begin
                r_bad  <= req_range;
                r_sidx <= req_frame[12 +: SUM_BITS];
                r_sbit <= req_frame[11:6];
                r_word <= req_frame[6 +: WORD_BITS];
                r_bit  <= req_frame[5:0];
            end
        end else if (r_state == S_RDS) begin
            r_sbit <= sum_low;
            r_word <= alloc_word[WORD_BITS-1:0];
        end
        if (complete) begin
            r_out_addr   <= n_out_addr;
            r_out_status <= n_out_status;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.result_address = r_out_addr;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.free_count     = r_free;

`ifndef SYNTHESIS
    a_oom_only_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && r_alloc && r_bad) |-> (r_top == '0))
        else $error("out of memory reported while a summary flag is set");

    a_summary_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDS) |-> (r_sum_q != '0))
        else $error("selected summary word has no free map word");

    a_alloc_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (complete && r_alloc && !r_bad && r_free != '0) |=> (r_free == $past(r_free) - 17'd1))
        else $error("free count not decremented on allocation");

    a_free_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({16'd0, r_free} <= FREE_LIMIT))
        else $error("free count exceeds the number of frames");
`endif

endmodule
